// ===== rtl/frt_pkg.sv =====
package frt_pkg;

	localparam int unsigned SLOTS_DEF         = 32;
	localparam int unsigned MAX_FRAGMENTS_DEF = 64;
	localparam int unsigned CHUNK_BYTES_DEF   = 1024;
	localparam int unsigned HEADER_BYTES_DEF  = 16;

	localparam int unsigned LEN_W   = 11;
	localparam int unsigned TAG_W   = 32;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned PEER_W  = 8;
	localparam int unsigned BYTES_W = 17;
	localparam int unsigned OFS_W   = 16;
	localparam int unsigned SLOT_FIELD_W = 5;

	localparam logic [BYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

	typedef enum logic [1:0] {
		STATUS_PARTIAL = 2'd0,
		STATUS_DONE    = 2'd1,
		STATUS_SHORT   = 2'd2,
		STATUS_BAD     = 2'd3
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [TAG_W-1:0]  tag;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  index;
		logic [PEER_W-1:0] peer;
	} frt_hdr_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [CNT_W-1:0]   expected;
		logic [CNT_W-1:0]   got_count;
		logic [BYTES_W-1:0] got_bytes;
		logic [PEER_W-1:0]  peer;
	} frt_entry_t;

	typedef struct packed {
		status_t                 status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [OFS_W-1:0]        offset;
		logic [LEN_W-1:0]        length;
		logic                    evicted;
		logic [PEER_W-1:0]       done_peer;
		logic [BYTES_W-1:0]      done_bytes;
	} frt_result_t;

	typedef struct packed {
		logic write;
		logic free;
	} frt_wr_ctl_t;

endpackage

// ===== rtl/frt_slot_map.sv =====
module frt_slot_map #(
	parameter int unsigned SLOTS  = frt_pkg::SLOTS_DEF,
	parameter int unsigned SLOT_W = 5
) (
	input  logic [frt_pkg::TAG_W-1:0] tag,
	output logic [SLOT_W-1:0]         slot
);

	// Each tag byte is reduced through its own residue table; the four residues
	// are then summed and brought below SLOTS.
	logic [7:0] res [4];
	logic [9:0] sum;
	logic [9:0] red;

	for (genvar i = 0; i < 4; i++) begin : g_byte
		localparam int unsigned PW = (1 << (8 * i)) % SLOTS;
		logic [7:0] tab [256];
		for (genvar b = 0; b < 256; b++) begin : g_ent
			localparam int unsigned V = (b * PW) % SLOTS;
			assign tab[b] = 8'(V);
		end
		assign res[i] = tab[tag[8*i +: 8]];
	end

	always_comb begin
		sum = 10'(res[0]) + 10'(res[1]) + 10'(res[2]) + 10'(res[3]);
		red = sum;
		for (int k = 0; k < 3; k++) begin
			if (red >= 10'(SLOTS)) begin
				red = red - 10'(SLOTS);
			end
		end
	end

	assign slot = SLOT_W'(red);

endmodule

// ===== rtl/frt_slot_mem.sv =====
module frt_slot_mem #(
	parameter int unsigned DEPTH  = frt_pkg::SLOTS_DEF,
	parameter int unsigned ADDR_W = 5,
	parameter int unsigned WIDTH  = 8
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/frt_update.sv =====
module frt_update #(
	parameter int unsigned MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
	parameter int unsigned CHUNK_BYTES   = frt_pkg::CHUNK_BYTES_DEF,
	parameter int unsigned HEADER_BYTES  = frt_pkg::HEADER_BYTES_DEF
) (
	input  frt_pkg::frt_hdr_t                     hdr,
	input  logic [frt_pkg::SLOT_FIELD_W-1:0]      slot,
	input  logic                                  slot_valid,
	input  frt_pkg::frt_entry_t                   rd_entry,
	input  logic [MAX_FRAGMENTS-1:0]              rd_arrived,
	output frt_pkg::frt_entry_t                   wr_entry,
	output logic [MAX_FRAGMENTS-1:0]              wr_arrived,
	output frt_pkg::frt_wr_ctl_t                  ctl,
	output frt_pkg::frt_result_t                  result
);

	logic                                 short_len;
	logic                                 bad;
	logic                                 hit;
	logic                                 fresh;
	logic                                 complete;
	logic [frt_pkg::LEN_W-1:0]            payload;
	logic [frt_pkg::CNT_W-1:0]            use_cnt;
	logic [frt_pkg::CNT_W-1:0]            idx_m1;
	logic [frt_pkg::CNT_W-1:0]            new_cnt;
	logic [frt_pkg::BYTES_W:0]            sum;
	logic [frt_pkg::BYTES_W-1:0]          sat;
	logic [31:0]                          ofs_full;
	logic [MAX_FRAGMENTS-1:0]             bit_mask;
	logic [MAX_FRAGMENTS-1:0]             base_arr;
	frt_pkg::frt_entry_t                  base;

	always_comb begin
		short_len = hdr.len < frt_pkg::LEN_W'(HEADER_BYTES);
		payload   = hdr.len - frt_pkg::LEN_W'(HEADER_BYTES);
		hit       = slot_valid && (rd_entry.tag == hdr.tag);
		use_cnt   = hit ? rd_entry.expected : hdr.count;
		bad       = (hdr.count == '0) || (hdr.count > frt_pkg::CNT_W'(MAX_FRAGMENTS)) ||
		            (hdr.index == '0) || (hdr.index > use_cnt) ||
		            (payload > frt_pkg::LEN_W'(CHUNK_BYTES));

		if (hit) begin
			base     = rd_entry;
			base_arr = rd_arrived;
		end else begin
			base.tag       = hdr.tag;
			base.expected  = hdr.count;
			base.got_count = '0;
			base.got_bytes = '0;
			base.peer      = hdr.peer;
			base_arr       = '0;
		end

		idx_m1   = hdr.index - frt_pkg::CNT_W'(1);
		bit_mask = MAX_FRAGMENTS'(1) << idx_m1;
		fresh    = (base_arr & bit_mask) == '0;
		new_cnt  = base.got_count + frt_pkg::CNT_W'(fresh);
		sum      = {1'b0, base.got_bytes} + (frt_pkg::BYTES_W + 1)'(payload);
		sat      = (sum > {1'b0, frt_pkg::BYTES_MAX}) ? frt_pkg::BYTES_MAX
		                                              : sum[frt_pkg::BYTES_W-1:0];
		complete = new_cnt == base.expected;
		ofs_full = 32'(idx_m1) * 32'(CHUNK_BYTES);

		wr_entry           = base;
		wr_entry.got_count = new_cnt;
		wr_entry.got_bytes = sat;
		wr_arrived         = base_arr | bit_mask;

		result = '0;
		ctl    = '0;
		priority if (short_len) begin
			result.status = frt_pkg::STATUS_SHORT;
		end else if (bad) begin
			result.status = frt_pkg::STATUS_BAD;
			result.slot   = slot;
		end else begin
			result.status  = complete ? frt_pkg::STATUS_DONE : frt_pkg::STATUS_PARTIAL;
			result.slot    = slot;
			result.offset  = ofs_full[frt_pkg::OFS_W-1:0];
			result.length  = payload;
			result.evicted = !hit && slot_valid;
			if (complete) begin
				result.done_peer  = base.peer;
				result.done_bytes = sat;
			end
			ctl.write = 1'b1;
			ctl.free  = complete;
		end
	end

endmodule

// ===== rtl/fragment_reassembly_table_core.sv =====
// Fragment reassembly table.
// Result path: the header and its slot entry read are registered when the header is accepted;
// the result is registered, and any updated slot entry written back, once the result register is free.
// Headers are taken one at a time: hdr_stall holds off the next header until that point.
// Reset: the control state and the per-slot valid bits clear at once; there is no
// clearing pass, and the slot memory contents stay undefined until written.
module fragment_reassembly_table_core #(
	parameter int unsigned SLOTS         = frt_pkg::SLOTS_DEF,
	parameter int unsigned MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
	parameter int unsigned CHUNK_BYTES   = frt_pkg::CHUNK_BYTES_DEF,
	parameter int unsigned HEADER_BYTES  = frt_pkg::HEADER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              hdr_valid,
	output logic                              hdr_stall,
	input  logic [frt_pkg::LEN_W-1:0]         packet_len,
	input  logic [frt_pkg::TAG_W-1:0]         packet_tag,
	input  logic [frt_pkg::CNT_W-1:0]         frag_count,
	input  logic [frt_pkg::CNT_W-1:0]         frag_index,
	input  logic [frt_pkg::PEER_W-1:0]        peer_in,

	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [1:0]                        status,
	output logic [frt_pkg::SLOT_FIELD_W-1:0]  slot_used,
	output logic [frt_pkg::OFS_W-1:0]         write_offset,
	output logic [frt_pkg::LEN_W-1:0]         write_length,
	output logic                              evicted,
	output logic [frt_pkg::PEER_W-1:0]        done_peer,
	output logic [frt_pkg::BYTES_W-1:0]       done_bytes
);

	localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned ENTRY_W = $bits(frt_pkg::frt_entry_t) + MAX_FRAGMENTS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	state_t                  state_q;
	logic                    accept;
	logic                    advance;
	logic [SLOT_W-1:0]       slot_in;
	logic [SLOT_W-1:0]       slot_s1;
	logic [7:0]              slot_ext;
	frt_pkg::frt_hdr_t       hdr_s1;
	logic [SLOTS-1:0]        slot_valid_q;
	logic [ENTRY_W-1:0]      rd_data;
	logic [ENTRY_W-1:0]      wr_data;
	frt_pkg::frt_entry_t     rd_entry;
	frt_pkg::frt_entry_t     wr_entry;
	logic [MAX_FRAGMENTS-1:0] rd_arrived;
	logic [MAX_FRAGMENTS-1:0] wr_arrived;
	frt_pkg::frt_wr_ctl_t    ctl;
	frt_pkg::frt_result_t    result;
	frt_pkg::frt_result_t    res_q;
	logic                    res_valid_q;

	assign hdr_stall = state_q != ST_IDLE;
	assign accept    = hdr_valid && !hdr_stall;
	assign advance   = (state_q == ST_CALC) && (!res_valid_q || !res_stall);

	frt_slot_map #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W)
	) u_map (
		.tag  (packet_tag),
		.slot (slot_in)
	);

	assign rd_entry   = rd_data[ENTRY_W-1:MAX_FRAGMENTS];
	assign rd_arrived = rd_data[MAX_FRAGMENTS-1:0];
	assign wr_data    = {wr_entry, wr_arrived};

	frt_slot_mem #(
		.DEPTH  (SLOTS),
		.ADDR_W (SLOT_W),
		.WIDTH  (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_in),
		.rd_data (rd_data),
		.wr_en   (advance && ctl.write),
		.wr_addr (slot_s1),
		.wr_data (wr_data)
	);

	assign slot_ext = 8'(slot_s1);

	frt_update #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS),
		.CHUNK_BYTES   (CHUNK_BYTES),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_update (
		.hdr        (hdr_s1),
		.slot       (slot_ext[frt_pkg::SLOT_FIELD_W-1:0]),
		.slot_valid (slot_valid_q[slot_s1]),
		.rd_entry   (rd_entry),
		.rd_arrived (rd_arrived),
		.wr_entry   (wr_entry),
		.wr_arrived (wr_arrived),
		.ctl        (ctl),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1.len   <= packet_len;
			hdr_s1.tag   <= packet_tag;
			hdr_s1.count <= frag_count;
			hdr_s1.index <= frag_index;
			hdr_s1.peer  <= peer_in;
			slot_s1      <= slot_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (advance && ctl.write) begin
			slot_valid_q[slot_s1] <= !ctl.free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = res_q.status;
	assign slot_used    = res_q.slot;
	assign write_offset = res_q.offset;
	assign write_length = res_q.length;
	assign evicted      = res_q.evicted;
	assign done_peer    = res_q.done_peer;
	assign done_bytes   = res_q.done_bytes;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int unsigned LEN_W             = frt_pkg::LEN_W;
	localparam int unsigned TAG_W             = frt_pkg::TAG_W;
	localparam int unsigned CNT_W             = frt_pkg::CNT_W;
	localparam int unsigned PEER_W            = frt_pkg::PEER_W;
	localparam int unsigned BYTES_W           = frt_pkg::BYTES_W;
	localparam int unsigned OFS_W             = frt_pkg::OFS_W;
	localparam int unsigned SLOT_FIELD_W      = frt_pkg::SLOT_FIELD_W;
	localparam int unsigned SLOTS_DEF         = frt_pkg::SLOTS_DEF;
	localparam int unsigned MAX_FRAGMENTS_DEF = frt_pkg::MAX_FRAGMENTS_DEF;
	localparam int unsigned CHUNK_BYTES_DEF   = frt_pkg::CHUNK_BYTES_DEF;
	localparam int unsigned HEADER_BYTES_DEF  = frt_pkg::HEADER_BYTES_DEF;
	localparam logic [BYTES_W-1:0] BYTES_MAX  = frt_pkg::BYTES_MAX;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS   = 1300;
	localparam int unsigned PHASE_ITEMS    = 160;

	typedef struct packed {
		frt_pkg::frt_hdr_t    hdr;
		logic                 chk;
		frt_pkg::frt_result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    hdr_valid = 1'b0;
	logic                    hdr_stall;
	logic [LEN_W-1:0]        packet_len = '0;
	logic [TAG_W-1:0]        packet_tag = '0;
	logic [CNT_W-1:0]        frag_count = '0;
	logic [CNT_W-1:0]        frag_index = '0;
	logic [PEER_W-1:0]       peer_in = '0;

	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [1:0]              status;
	logic [SLOT_FIELD_W-1:0] slot_used;
	logic [OFS_W-1:0]        write_offset;
	logic [LEN_W-1:0]        write_length;
	logic                    evicted;
	logic [PEER_W-1:0]       done_peer;
	logic [BYTES_W-1:0]      done_bytes;

	logic               tbl_valid [SLOTS_DEF];
	logic [TAG_W-1:0]   tbl_tag [SLOTS_DEF];
	logic [CNT_W-1:0]   tbl_expected [SLOTS_DEF];
	logic [CNT_W-1:0]   tbl_got [SLOTS_DEF];
	logic [BYTES_W-1:0] tbl_bytes [SLOTS_DEF];
	logic [PEER_W-1:0]  tbl_peer [SLOTS_DEF];
	logic [63:0]        tbl_arrived [SLOTS_DEF];

	frt_pkg::frt_result_t pending_results [$];
	dir_row_t             dir_rows [$];
	frt_pkg::frt_hdr_t    frag_a_q [$];
	frt_pkg::frt_hdr_t    frag_b_q [$];

	int unsigned hdr_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;

	fragment_reassembly_table_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.hdr_valid    (hdr_valid),
		.hdr_stall    (hdr_stall),
		.packet_len   (packet_len),
		.packet_tag   (packet_tag),
		.frag_count   (frag_count),
		.frag_index   (frag_index),
		.peer_in      (peer_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.slot_used    (slot_used),
		.write_offset (write_offset),
		.write_length (write_length),
		.evicted      (evicted),
		.done_peer    (done_peer),
		.done_bytes   (done_bytes)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic frt_pkg::frt_result_t frag_table_update(frt_pkg::frt_hdr_t h);
		frt_pkg::frt_result_t r;
		logic [SLOT_FIELD_W-1:0] s;
		logic [LEN_W-1:0] payload;
		logic [CNT_W-1:0] use_cnt;
		logic hit;
		logic [63:0] bit_m;
		int unsigned sum;
		r = '0;
		if (h.len < HEADER_BYTES_DEF) begin
			r.status = frt_pkg::STATUS_SHORT;
			return r;
		end
		payload = LEN_W'(h.len - HEADER_BYTES_DEF);
		s = SLOT_FIELD_W'(h.tag % SLOTS_DEF);
		r.slot = s;
		hit = tbl_valid[s] && (tbl_tag[s] == h.tag);
		use_cnt = hit ? tbl_expected[s] : h.count;
		if (h.count == 0 || h.count > MAX_FRAGMENTS_DEF || h.index == 0 ||
				h.index > use_cnt || payload > CHUNK_BYTES_DEF) begin
			r.status = frt_pkg::STATUS_BAD;
			return r;
		end
		if (!hit) begin
			r.evicted = tbl_valid[s];
			tbl_valid[s] = 1'b1;
			tbl_tag[s] = h.tag;
			tbl_expected[s] = h.count;
			tbl_got[s] = '0;
			tbl_bytes[s] = '0;
			tbl_peer[s] = h.peer;
			tbl_arrived[s] = '0;
		end
		r.offset = OFS_W'((h.index - 1) * CHUNK_BYTES_DEF);
		r.length = payload;
		bit_m = 64'd1 << (h.index - 1);
		if ((tbl_arrived[s] & bit_m) == 64'd0) begin
			tbl_arrived[s] = tbl_arrived[s] | bit_m;
			tbl_got[s] = tbl_got[s] + CNT_W'(1);
		end
		sum = 32'(tbl_bytes[s]) + 32'(payload);
		tbl_bytes[s] = (sum > BYTES_MAX) ? BYTES_MAX : BYTES_W'(sum);
		r.status = frt_pkg::STATUS_PARTIAL;
		if (tbl_got[s] == tbl_expected[s]) begin
			r.status = frt_pkg::STATUS_DONE;
			r.done_peer = tbl_peer[s];
			r.done_bytes = tbl_bytes[s];
			tbl_valid[s] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return LEN_W'(HEADER_BYTES_DEF);
		if (r == 1)
			return LEN_W'(HEADER_BYTES_DEF + CHUNK_BYTES_DEF);
		return LEN_W'($urandom_range(HEADER_BYTES_DEF + CHUNK_BYTES_DEF, HEADER_BYTES_DEF));
	endfunction

	task automatic issue_header(input frt_pkg::frt_hdr_t h, input logic chk,
			input frt_pkg::frt_result_t want);
		frt_pkg::frt_result_t r;
		case ((hdr_sent / PHASE_ITEMS) % 4)
			0: begin
				send_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 55;
				rcv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				rcv_stall_pct = 55;
			end
			default: begin
				send_idle_pct = 23;
				rcv_stall_pct = 23;
			end
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			hdr_valid <= 1'b0;
			@(posedge clk);
		end
		hdr_valid <= 1'b1;
		packet_len <= h.len;
		packet_tag <= h.tag;
		frag_count <= h.count;
		frag_index <= h.index;
		peer_in <= h.peer;
		@(posedge clk);
		while (hdr_stall)
			@(posedge clk);
		r = frag_table_update(h);
		pending_results = {pending_results, (chk ? want : r)};
		hdr_sent++;
	endtask

	task automatic add_row(input int unsigned len, input logic [TAG_W-1:0] tag,
			input int unsigned cnt, input int unsigned idx, input int unsigned peer,
			input logic chk, input frt_pkg::status_t st, input int unsigned slot,
			input int unsigned ofs, input int unsigned wlen, input logic ev,
			input int unsigned dpeer, input int unsigned dbytes);
		dir_row_t row;
		row.hdr.len = LEN_W'(len);
		row.hdr.tag = tag;
		row.hdr.count = CNT_W'(cnt);
		row.hdr.index = CNT_W'(idx);
		row.hdr.peer = PEER_W'(peer);
		row.chk = chk;
		row.want.status = st;
		row.want.slot = SLOT_FIELD_W'(slot);
		row.want.offset = OFS_W'(ofs);
		row.want.length = LEN_W'(wlen);
		row.want.evicted = ev;
		row.want.done_peer = PEER_W'(dpeer);
		row.want.done_bytes = BYTES_W'(dbytes);
		dir_rows = {dir_rows, row};
	endtask

	task automatic queue_frag(input logic lane, input frt_pkg::frt_hdr_t h);
		if (lane)
			frag_b_q = {frag_b_q, h};
		else
			frag_a_q = {frag_a_q, h};
	endtask

	task automatic build_packet(input logic lane);
		frt_pkg::frt_hdr_t h;
		logic [CNT_W-1:0] order [64];
		logic [CNT_W-1:0] t;
		int unsigned n, j, k, stop_at;
		if ($urandom_range(1))
			h.tag = ($urandom_range(3) << 5) | $urandom_range(7);
		else
			h.tag = $urandom;
		n = ($urandom_range(9) == 0) ? $urandom_range(MAX_FRAGMENTS_DEF, 1)
		                              : $urandom_range(8, 1);
		h.count = CNT_W'(n);
		h.peer = PEER_W'($urandom_range(255));
		for (k = 0; k < n; k++)
			order[k] = CNT_W'(k + 1);
		for (k = n - 1; k > 0; k--) begin
			j = $urandom_range(k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		stop_at = ($urandom_range(99) < 15) ? $urandom_range(n - 1) : n;
		for (k = 0; k < stop_at; k++) begin
			h.index = order[k];
			h.len = pick_len();
			if ($urandom_range(9) == 0)
				h.count = CNT_W'($urandom_range(127));
			if ($urandom_range(9) == 0)
				h.peer = PEER_W'($urandom_range(255));
			queue_frag(lane, h);
			h.count = CNT_W'(n);
			if ($urandom_range(9) == 0) begin
				h.index = order[$urandom_range(k)];
				h.len = pick_len();
				queue_frag(lane, h);
			end
			if ($urandom_range(29) == 0) begin
				h.index = CNT_W'(n + 1 + $urandom_range(3));
				h.len = $urandom_range(1)
					? LEN_W'($urandom_range(HEADER_BYTES_DEF - 1))
					: pick_len();
				queue_frag(lane, h);
			end
		end
	endtask

	always @(posedge clk)
		res_stall <= ($urandom_range(99) < rcv_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin : result_check
		frt_pkg::frt_result_t got;
		frt_pkg::frt_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			got.status = frt_pkg::status_t'(status);
			got.slot = slot_used;
			got.offset = write_offset;
			got.length = write_length;
			got.evicted = evicted;
			got.done_peer = done_peer;
			got.done_bytes = done_bytes;
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("Result with no request pending: status %0d slot %0d",
						status, slot_used);
				mismatches++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (got.status !== want.status || got.slot !== want.slot ||
						got.offset !== want.offset || got.length !== want.length ||
						got.evicted !== want.evicted || got.done_peer !== want.done_peer ||
						got.done_bytes !== want.done_bytes) begin
					if (mismatches < 10)
						$display({"Mismatch: expected st %0d slot %0d ofs %0d len %0d ev %0d ",
							"peer %0d bytes %0d, got st %0d slot %0d ofs %0d len %0d ev %0d ",
							"peer %0d bytes %0d"},
							want.status, want.slot, want.offset, want.length, want.evicted,
							want.done_peer, want.done_bytes, got.status, got.slot, got.offset,
							got.length, got.evicted, got.done_peer, got.done_bytes);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		frt_pkg::frt_hdr_t h;
		frt_pkg::frt_hdr_t nxt;
		int unsigned k, n, first_random;
		for (k = 0; k < SLOTS_DEF; k++)
			tbl_valid[k] = 1'b0;

		add_row(0, 32'h0, 1, 1, 0, 1, frt_pkg::STATUS_SHORT, 0, 0, 0, 0, 0, 0);
		add_row(15, 32'h5, 1, 1, 0, 1, frt_pkg::STATUS_SHORT, 0, 0, 0, 0, 0, 0);
		add_row(16, 32'h5, 0, 1, 0, 1, frt_pkg::STATUS_BAD, 5, 0, 0, 0, 0, 0);
		add_row(40, 32'h5, 65, 1, 0, 1, frt_pkg::STATUS_BAD, 5, 0, 0, 0, 0, 0);
		add_row(40, 32'h6, 4, 0, 0, 1, frt_pkg::STATUS_BAD, 6, 0, 0, 0, 0, 0);
		add_row(40, 32'h7, 3, 4, 0, 1, frt_pkg::STATUS_BAD, 7, 0, 0, 0, 0, 0);
		add_row(1041, 32'h8, 3, 1, 0, 1, frt_pkg::STATUS_BAD, 8, 0, 0, 0, 0, 0);
		add_row(2047, 32'hFFFFFFFF, 127, 127, 255, 1, frt_pkg::STATUS_BAD,
			31, 0, 0, 0, 0, 0);
		add_row(1040, 32'hFFFFFFFF, 1, 1, 255, 1, frt_pkg::STATUS_DONE,
			31, 0, 1024, 0, 255, 1024);
		add_row(16, 32'h0, 1, 1, 0, 1, frt_pkg::STATUS_DONE, 0, 0, 0, 0, 0, 0);
		add_row(100, 32'h40, 64, 64, 7, 1, frt_pkg::STATUS_PARTIAL, 0, 64512, 84, 0, 0, 0);
		add_row(100, 32'h40, 64, 64, 7, 1, frt_pkg::STATUS_PARTIAL, 0, 64512, 84, 0, 0, 0);
		add_row(100, 32'h40, 5, 65, 7, 1, frt_pkg::STATUS_BAD, 0, 0, 0, 0, 0, 0);
		add_row(20, 32'h60, 2, 1, 9, 1, frt_pkg::STATUS_PARTIAL, 0, 0, 4, 1, 0, 0);
		add_row(20, 32'h60, 99, 2, 9, 1, frt_pkg::STATUS_BAD, 0, 0, 0, 0, 0, 0);
		add_row(30, 32'h60, 1, 2, 3, 1, frt_pkg::STATUS_DONE, 0, 1024, 14, 0, 9, 18);
		add_row(16, 32'h60, 2, 1, 1, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);
		add_row(1040, 32'h80, 2, 2, 2, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);
		add_row(500, 32'h12345677, 3, 3, 165, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);
		add_row(16, 32'h12345677, 3, 1, 165, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);
		add_row(1040, 32'h12345677, 3, 2, 165, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);
		add_row(17, 32'h80, 2, 1, 2, 0, frt_pkg::STATUS_PARTIAL, 0, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			issue_header(dir_rows[i].hdr, dir_rows[i].chk, dir_rows[i].want);
		first_random = hdr_sent;

		// The byte total only saturates after more than a hundred duplicate full chunks.
		h.tag = 32'h00ABCDE3;
		h.count = CNT_W'(MAX_FRAGMENTS_DEF);
		h.peer = 8'h5A;
		for (k = 0; k < 140; k++) begin
			h.index = 1;
			h.len = LEN_W'(HEADER_BYTES_DEF + CHUNK_BYTES_DEF);
			queue_frag(1'b0, h);
		end
		for (k = 2; k <= MAX_FRAGMENTS_DEF; k++) begin
			h.index = CNT_W'(k);
			h.len = pick_len();
			queue_frag(1'b0, h);
		end

		while (hdr_sent - first_random < RANDOM_ITEMS) begin
			if (frag_a_q.size() == 0 && frag_b_q.size() == 0) begin
				if ($urandom_range(99) < 12) begin
					n = $urandom_range(6, 1);
					for (k = 0; k < n; k++) begin
						h.len = LEN_W'($urandom_range(2047));
						h.tag = $urandom;
						h.count = CNT_W'($urandom_range(127));
						h.index = CNT_W'($urandom_range(127));
						h.peer = PEER_W'($urandom_range(255));
						queue_frag(1'b0, h);
					end
				end else begin
					build_packet(1'b0);
					if ($urandom_range(1))
						build_packet(1'b1);
				end
			end
			while (frag_a_q.size() != 0 || frag_b_q.size() != 0) begin
				if (frag_b_q.size() == 0 || (frag_a_q.size() != 0 && $urandom_range(1))) begin
					nxt = frag_a_q[0];
					frag_a_q.delete(0);
				end else begin
					nxt = frag_b_q[0];
					frag_b_q.delete(0);
				end
				issue_header(nxt, 1'b0, '0);
			end
		end
		hdr_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
